[rtl/alt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alt_pkg: shared types and constants of the assembly line tokenizer
// Item formats, token kind codes and the record passed from front to back.
// ----------------------------------------------------------------------------
package alt_pkg;

  // line length limit; positions saturate at LINE_MAX-1
  localparam int LINE_MAX = 256;
  localparam int POS_W    = $clog2(LINE_MAX);

  // depth of the record queue between front and back (power of two)
  localparam int REC_DEPTH = 4;

  // token kind codes
  localparam logic [3:0] TK_MNEMONIC   = 4'd0;
  localparam logic [3:0] TK_REGISTER   = 4'd1;
  localparam logic [3:0] TK_NUMBER     = 4'd2;
  localparam logic [3:0] TK_COMMA      = 4'd3;
  localparam logic [3:0] TK_COLON      = 4'd4;
  localparam logic [3:0] TK_OPEN       = 4'd5;
  localparam logic [3:0] TK_CLOSE      = 4'd6;
  localparam logic [3:0] TK_LABEL      = 4'd7;
  localparam logic [3:0] TK_DIRECTIVE  = 4'd8;
  localparam logic [3:0] TK_IDENTIFIER = 4'd9;
  localparam logic [3:0] TK_EOL        = 4'd10;
  localparam logic [3:0] TK_UNKNOWN    = 4'd11;

  // input item: one character of the line
  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } in_item_t;

  // result item: one token
  typedef struct packed {
    logic [3:0] token_kind;
    logic [4:0] keyword_index;
    logic [7:0] token_start;
    logic [7:0] token_length;
    logic       position_overflow;
    logic       last_of_run;
  } out_item_t;

  // one token inside a record
  typedef struct packed {
    logic [3:0] kind;
    logic [4:0] keyword_index;
    logic [7:0] start;
    logic [7:0] length;
  } tok_t;

  // all tokens caused by one character, oldest in slot 0
  typedef struct packed {
    tok_t [2:0] tok;
    logic [1:0] count;
    logic       ovf;
  } step_t;

endpackage

[rtl/assembly_line_tokenizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assembly_line_tokenizer: streaming lexer for one line of assembly text
// Scanner front, record queue and token serializer back end.
// ----------------------------------------------------------------------------
// the first token of a character passes through the record queue, then the output register
// throughput: one character per cycle while the four-record queue has room
// tokens leave one per cycle from a single output register while the consumer pops
// a character may cause up to three tokens, delivered one after another in order
// reset: synchronous rst clears scanner state, record queue and output
module assembly_line_tokenizer
  import alt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  source,
  output logic      empty,
  input  logic      pop,
  output out_item_t token
);

  step_t rec_in;
  step_t rec_out;
  logic  rec_push;
  logic  rec_full;
  logic  rec_pop;
  logic  rec_empty;

  // character scanner
  alt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .source   (source),
    .full     (full),
    .rec_full (rec_full),
    .rec_push (rec_push),
    .rec      (rec_in)
  );

  // record queue
  alt_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (rec_push),
    .wdata (rec_in),
    .full  (rec_full),
    .pop   (rec_pop),
    .rdata (rec_out),
    .empty (rec_empty)
  );

  // token serializer
  alt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec       (rec_out),
    .rec_empty (rec_empty),
    .rec_pop   (rec_pop),
    .token     (token),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

[rtl/alt_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alt_fifo: record queue between front and back
// Small register queue of step records; head is readable while not empty.
// ----------------------------------------------------------------------------
module alt_fifo
  import alt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  step_t wdata,
  output logic  full,
  input  logic  pop,
  output step_t rdata,
  output logic  empty
);

  localparam int PTR_W = $clog2(REC_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  step_t            mem [REC_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             do_push;
  logic             do_pop;

  // status
  assign full    = (cnt == CNT_W'(REC_DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  // fill count stays within the depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(REC_DEPTH))
    else $error("record queue count beyond depth");

endmodule

[rtl/alt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alt_front: character scanner
// Classifies each character, tracks the pending token and builds a record
// of up to three tokens for each character that yields any token.
// ----------------------------------------------------------------------------
module alt_front
  import alt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_item_t source,
  output logic     full,
  input  logic     rec_full,
  output logic     rec_push,
  output step_t    rec
);

  typedef enum logic [2:0] {
    M_IDLE,
    M_WORD,
    M_WAIT,
    M_ZERO,
    M_DEC,
    M_HEX
  } mode_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] kind;
    logic [4:0] idx;
  } kw_t;

  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_OPEN    = 8'h5B;
  localparam logic [7:0] CH_CLOSE   = 8'h5D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_X_UPPER = 8'h58;
  localparam logic [7:0] CH_X_LOWER = 8'h78;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_MAX - 1);

  // keyword table: mnemonics, then registers, then directives
  function automatic kw_t kw_lookup(logic [31:0] kbuf, logic [7:0] len);
    kw_t r;
    r = '0;
    r.hit = 1'b1;
    unique case (kbuf)
      {8'd0, "MOV"}:  begin r.kind = TK_MNEMONIC;  r.idx = 5'd0;  end
      {8'd0, "MVI"}:  begin r.kind = TK_MNEMONIC;  r.idx = 5'd1;  end
      {8'd0, "LDA"}:  begin r.kind = TK_MNEMONIC;  r.idx = 5'd2;  end
      {8'd0, "STA"}:  begin r.kind = TK_MNEMONIC;  r.idx = 5'd3;  end
      {8'd0, "ADD"}:  begin r.kind = TK_MNEMONIC;  r.idx = 5'd4;  end
      {8'd0, "SUB"}:  begin r.kind = TK_MNEMONIC;  r.idx = 5'd5;  end
      {8'd0, "INR"}:  begin r.kind = TK_MNEMONIC;  r.idx = 5'd6;  end
      {8'd0, "DCR"}:  begin r.kind = TK_MNEMONIC;  r.idx = 5'd7;  end
      {8'd0, "JMP"}:  begin r.kind = TK_MNEMONIC;  r.idx = 5'd8;  end
      {16'd0, "JC"}:  begin r.kind = TK_MNEMONIC;  r.idx = 5'd9;  end
      {8'd0, "JNC"}:  begin r.kind = TK_MNEMONIC;  r.idx = 5'd10; end
      {16'd0, "JZ"}:  begin r.kind = TK_MNEMONIC;  r.idx = 5'd11; end
      {8'd0, "JNZ"}:  begin r.kind = TK_MNEMONIC;  r.idx = 5'd12; end
      "CALL":         begin r.kind = TK_MNEMONIC;  r.idx = 5'd13; end
      {8'd0, "RET"}:  begin r.kind = TK_MNEMONIC;  r.idx = 5'd14; end
      {8'd0, "NOP"}:  begin r.kind = TK_MNEMONIC;  r.idx = 5'd15; end
      {8'd0, "HLT"}:  begin r.kind = TK_MNEMONIC;  r.idx = 5'd16; end
      {8'd0, "ANA"}:  begin r.kind = TK_MNEMONIC;  r.idx = 5'd17; end
      {8'd0, "ORA"}:  begin r.kind = TK_MNEMONIC;  r.idx = 5'd18; end
      {8'd0, "XRA"}:  begin r.kind = TK_MNEMONIC;  r.idx = 5'd19; end
      {8'd0, "CMP"}:  begin r.kind = TK_MNEMONIC;  r.idx = 5'd20; end
      "PUSH":         begin r.kind = TK_MNEMONIC;  r.idx = 5'd21; end
      {8'd0, "POP"}:  begin r.kind = TK_MNEMONIC;  r.idx = 5'd22; end
      {24'd0, "A"}:   begin r.kind = TK_REGISTER;  r.idx = 5'd0;  end
      {24'd0, "B"}:   begin r.kind = TK_REGISTER;  r.idx = 5'd1;  end
      {24'd0, "C"}:   begin r.kind = TK_REGISTER;  r.idx = 5'd2;  end
      {24'd0, "D"}:   begin r.kind = TK_REGISTER;  r.idx = 5'd3;  end
      {24'd0, "E"}:   begin r.kind = TK_REGISTER;  r.idx = 5'd4;  end
      {24'd0, "H"}:   begin r.kind = TK_REGISTER;  r.idx = 5'd5;  end
      {24'd0, "L"}:   begin r.kind = TK_REGISTER;  r.idx = 5'd6;  end
      {24'd0, "M"}:   begin r.kind = TK_REGISTER;  r.idx = 5'd7;  end
      {16'd0, "SP"}:  begin r.kind = TK_REGISTER;  r.idx = 5'd8;  end
      {8'd0, "PSW"}:  begin r.kind = TK_REGISTER;  r.idx = 5'd9;  end
      {16'd0, "HL"}:  begin r.kind = TK_REGISTER;  r.idx = 5'd10; end
      {16'd0, "DE"}:  begin r.kind = TK_REGISTER;  r.idx = 5'd11; end
      {16'd0, "BC"}:  begin r.kind = TK_REGISTER;  r.idx = 5'd12; end
      {8'd0, "ORG"}:  begin r.kind = TK_DIRECTIVE; r.idx = 5'd0;  end
      {16'd0, "DB"}:  begin r.kind = TK_DIRECTIVE; r.idx = 5'd1;  end
      {16'd0, "DW"}:  begin r.kind = TK_DIRECTIVE; r.idx = 5'd2;  end
      {8'd0, "END"}:  begin r.kind = TK_DIRECTIVE; r.idx = 5'd3;  end
      default:        r.hit = 1'b0;
    endcase
    // words longer than four characters never match
    if (len > 8'd4) begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

  // line and token state
  mode_t            mode;
  logic [POS_W-1:0] line_position;
  logic             slot_used;
  logic [POS_W-1:0] pending_start;
  logic [7:0]       pending_length;
  logic [31:0]      keyword_buffer;
  logic             overflow_seen;

  // per-character values
  logic             accept;
  logic [7:0]       c;
  logic [7:0]       c_up;
  logic             c_space;
  logic             c_alpha;
  logic             c_digit;
  logic             c_hex;
  logic             c_wstart;
  logic             c_word;
  logic [POS_W-1:0] cur_pos;
  logic [POS_W-1:0] pos_after;
  logic             slot_after;
  logic             ovf;
  logic [7:0]       len_inc;
  kw_t              kw_now;
  kw_t              kw_end;

  // fresh-start decode
  mode_t            fresh_mode;
  logic             fresh_pend;
  logic             fresh_tok_v;
  logic [3:0]       fresh_kind;

  // state after the main step
  mode_t            mode_m;
  logic [POS_W-1:0] start_m;
  logic [7:0]       len_m;
  logic [31:0]      buf_m;
  logic             do_fresh;

  // candidate tokens in emission order
  tok_t             cand [4];
  logic [3:0]       cand_v;
  logic [1:0]       n;

  assign accept = push && !full;
  assign full   = rec_full;
  assign c      = source.char_code;

  // character classes
  always_comb begin
    c_space  = (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    c_alpha  = (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    c_digit  = (c >= 8'd48 && c <= 8'd57);
    c_hex    = c_digit || (c >= 8'd65 && c <= 8'd70) || (c >= 8'd97 && c <= 8'd102);
    c_wstart = c_alpha || (c == CH_DOT) || (c == CH_UNDER);
    c_word   = c_wstart || c_digit;
    c_up     = (c >= 8'd97 && c <= 8'd122) ? c - 8'd32 : c;
  end

  // position bookkeeping with saturation
  always_comb begin
    cur_pos    = slot_used ? POS_LAST : line_position;
    ovf        = overflow_seen || slot_used;
    pos_after  = (line_position < POS_LAST) ? line_position + POS_W'(1) : line_position;
    slot_after = slot_used || (line_position == POS_LAST);
    len_inc    = (pending_length == 8'd255) ? pending_length : pending_length + 8'd1;
    kw_now     = kw_lookup(keyword_buffer, pending_length);
  end

  // what a character starts when no token is pending
  always_comb begin
    fresh_mode  = M_IDLE;
    fresh_pend  = 1'b0;
    fresh_tok_v = 1'b0;
    fresh_kind  = TK_UNKNOWN;
    if (c_wstart) begin
      fresh_mode = M_WORD;
      fresh_pend = 1'b1;
    end else if (c_digit) begin
      fresh_mode = (c == CH_ZERO) ? M_ZERO : M_DEC;
      fresh_pend = 1'b1;
    end else begin
      case (c)
        CH_COMMA: begin fresh_tok_v = 1'b1; fresh_kind = TK_COMMA; end
        CH_COLON: begin fresh_tok_v = 1'b1; fresh_kind = TK_COLON; end
        CH_OPEN:  begin fresh_tok_v = 1'b1; fresh_kind = TK_OPEN;  end
        CH_CLOSE: begin fresh_tok_v = 1'b1; fresh_kind = TK_CLOSE; end
        default:  fresh_tok_v = !c_space;
      endcase
    end
  end

  // main scan step
  always_comb begin
    mode_m   = mode;
    start_m  = pending_start;
    len_m    = pending_length;
    buf_m    = keyword_buffer;
    do_fresh = 1'b0;
    cand[0]  = '0;
    cand_v   = '0;
    cand[0].start  = 8'(pending_start);
    cand[0].length = pending_length;
    unique case (mode)
      M_WORD: begin
        if (c_word) begin
          len_m = len_inc;
          buf_m = {keyword_buffer[23:0], c_up};
        end else if (kw_now.hit) begin
          cand_v[0]             = 1'b1;
          cand[0].kind          = kw_now.kind;
          cand[0].keyword_index = kw_now.idx;
          do_fresh              = 1'b1;
        end else if (c_space) begin
          mode_m = M_WAIT;
        end else begin
          cand_v[0]    = 1'b1;
          cand[0].kind = (c == CH_COLON) ? TK_LABEL : TK_IDENTIFIER;
          do_fresh     = 1'b1;
        end
      end
      M_WAIT: begin
        if (!c_space) begin
          cand_v[0]    = 1'b1;
          cand[0].kind = (c == CH_COLON) ? TK_LABEL : TK_IDENTIFIER;
          do_fresh     = 1'b1;
        end
      end
      M_ZERO: begin
        if (c == CH_X_UPPER || c == CH_X_LOWER) begin
          len_m  = len_inc;
          mode_m = M_HEX;
        end else if (c_digit) begin
          len_m  = len_inc;
          mode_m = M_DEC;
        end else begin
          cand_v[0]    = 1'b1;
          cand[0].kind = TK_NUMBER;
          do_fresh     = 1'b1;
        end
      end
      M_DEC: begin
        if (c_digit) begin
          len_m = len_inc;
        end else begin
          cand_v[0]    = 1'b1;
          cand[0].kind = TK_NUMBER;
          do_fresh     = 1'b1;
        end
      end
      M_HEX: begin
        if (c_hex) begin
          len_m = len_inc;
        end else begin
          cand_v[0]    = 1'b1;
          cand[0].kind = TK_NUMBER;
          do_fresh     = 1'b1;
        end
      end
      default: do_fresh = 1'b1;
    endcase

    // fresh start after a closed token or from idle
    cand[1]        = '0;
    cand[1].kind   = fresh_kind;
    cand[1].start  = 8'(cur_pos);
    cand[1].length = 8'd1;
    cand_v[1]      = do_fresh && fresh_tok_v;
    if (do_fresh) begin
      mode_m = fresh_mode;
      if (fresh_pend) begin
        start_m = cur_pos;
        len_m   = 8'd1;
        buf_m   = {24'd0, c_up};
      end
    end

    // line end closes the pending token
    kw_end         = kw_lookup(buf_m, len_m);
    cand[2]        = '0;
    cand[2].start  = 8'(start_m);
    cand[2].length = len_m;
    if (source.line_end) begin
      case (mode_m)
        M_WORD: begin
          cand_v[2]             = 1'b1;
          cand[2].kind          = kw_end.hit ? kw_end.kind : TK_IDENTIFIER;
          cand[2].keyword_index = kw_end.hit ? kw_end.idx : 5'd0;
        end
        M_WAIT: begin
          cand_v[2]    = 1'b1;
          cand[2].kind = TK_IDENTIFIER;
        end
        M_ZERO, M_DEC, M_HEX: begin
          cand_v[2]    = 1'b1;
          cand[2].kind = TK_NUMBER;
        end
        default: cand_v[2] = 1'b0;
      endcase
    end

    // end-of-line token
    cand[3]       = '0;
    cand[3].kind  = TK_EOL;
    cand[3].start = 8'(pos_after);
    cand_v[3]     = source.line_end;
  end

  // pack valid candidates into the record
  always_comb begin
    rec     = '0;
    rec.ovf = ovf;
    n       = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i] && n != 2'd3) begin
        rec.tok[n] = cand[i];
        n          = n + 2'd1;
      end
    end
    rec.count = n;
    rec_push  = accept && (n != 2'd0);
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (rst || (accept && source.line_end)) begin
      mode           <= M_IDLE;
      line_position  <= '0;
      slot_used      <= 1'b0;
      pending_start  <= '0;
      pending_length <= '0;
      keyword_buffer <= '0;
      overflow_seen  <= 1'b0;
    end else if (accept) begin
      mode           <= mode_m;
      line_position  <= pos_after;
      slot_used      <= slot_after;
      pending_start  <= start_m;
      pending_length <= len_m;
      keyword_buffer <= buf_m;
      overflow_seen  <= ovf;
    end
  end

  // a line end always yields a record closed by the end-of-line token
  a_eol_last: assert property (@(posedge clk) disable iff (rst)
    (accept && source.line_end) |->
      (rec_push && rec.tok[rec.count - 2'd1].kind == TK_EOL))
    else $error("line end without trailing end-of-line token");

  // a line end leaves the scanner at the start of a fresh line
  a_eol_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && source.line_end) |=>
      (mode == M_IDLE && line_position == '0 && !slot_used && !overflow_seen))
    else $error("scanner state not cleared after line end");

endmodule

[rtl/alt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alt_back: token serializer
// Walks the head record one token per cycle into the output register while it is free or popped.
// ----------------------------------------------------------------------------
module alt_back
  import alt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  step_t     rec,
  input  logic      rec_empty,
  output logic      rec_pop,
  output out_item_t token,
  output logic      empty,
  input  logic      pop
);

  logic       out_valid;
  logic [1:0] sel;
  logic       load;
  logic       last;
  tok_t       cur;

  // output register is free when empty or being taken
  assign load    = !rec_empty && (!out_valid || pop);
  assign last    = (sel == rec.count - 2'd1);
  assign rec_pop = load && last;
  assign cur     = rec.tok[sel];
  assign empty   = !out_valid;

  // token select and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sel       <= last ? 2'd0 : sel + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      token.token_kind        <= cur.kind;
      token.keyword_index     <= cur.keyword_index;
      token.token_start       <= cur.start;
      token.token_length      <= cur.length;
      token.position_overflow <= rec.ovf;
      token.last_of_run       <= last;
    end
  end

  // the select never runs past the tokens of the head record
  a_sel_range: assert property (@(posedge clk) disable iff (rst)
    !rec_empty |-> (sel < rec.count))
    else $error("token select beyond record count");

  // retiring a record presents its final token next
  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    rec_pop |=> (!empty && token.last_of_run))
    else $error("record retired without final token");

endmodule
